[design/bfm_pkg.sv]
// ----------------------------------------------------------------------------
// bfm_pkg: shared types and constants of the 5x5 mirrored box filter
// Window geometry, counter widths, result FIFO sizing, the reciprocal
// used for the divide by 25, and the mirrored tap index function.
// ----------------------------------------------------------------------------
`default_nettype none

package bfm_pkg;

    localparam int WIN   = 5;
    localparam int RAD   = WIN / 2;
    localparam int LANES = WIN - 1;

    // row counter runs to size+1, so one bit beyond the 9-bit size
    localparam int CW = 10;

    localparam int FIFO_DEPTH = 32;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNTW  = FIFO_AW + 1;

    // floor(sum / 25) == (sum * 5243) >> 17 for every sum up to 25*255
    localparam logic [12:0] RECIP       = 13'd5243;
    localparam int          RECIP_SHIFT = 17;

    localparam logic [1:0] REG_IMAGE_SIZE    = 2'd0;
    localparam logic [1:0] REG_CHANNEL_COUNT = 2'd1;

    typedef logic [23:0] t_pix;

    typedef struct packed {
        logic [7:0] ch0;
        logic [7:0] ch1;
        logic [7:0] ch2;
        logic       row_end;
        logic       frame_end;
    } t_res;

    // up to three results written to the FIFO in one cycle, slots from 0
    typedef struct packed {
        logic [1:0]       cnt;
        t_res [2:0]       slot;
    } t_res_group;

    // Window tap for position v of the output neighborhood: mirror about
    // the edge pixel, then map image index to window slot (now is newest).
    function automatic logic [2:0] f_tap(input logic signed [11:0] v,
                                         input logic signed [11:0] s,
                                         input logic signed [11:0] now);
        logic signed [11:0] m;
        logic signed [11:0] t;
        m = (v < 12'sd0) ? -v : v;
        if (m >= s) begin
            m = 12'sd2 * (s - 12'sd1) - m;
        end
        if (m < 12'sd0) begin
            m = 12'sd0;
        end
        if (m > s - 12'sd1) begin
            m = s - 12'sd1;
        end
        t = m - (now - 12'(2 * RAD));
        if (t < 12'sd0) begin
            return 3'd0;
        end
        if (t > 12'(2 * RAD)) begin
            return 3'(2 * RAD);
        end
        return t[2:0];
    endfunction

endpackage

`default_nettype wire

[design/box_filter_5x5_mirror_core.sv]
// ----------------------------------------------------------------------------
// box_filter_5x5_mirror_core: streaming 5x5 mean filter with mirrored edges
// Raster pixels in, truncated 25-pixel means out, two rows and two columns
// behind, with drain beats for the two virtual rows below the image.
//
//   channel   direction  handshake          payload
//   pixel     in         i_valid / o_stall  i_action, i_in_ch0..2
//   result    out        o_valid / i_stall  o_out_ch0..2, o_row_end, o_frame_end
//   config    in         i_cfg_we           i_cfg_index, i_cfg_data
//
// One pixel beat is taken per cycle while o_stall is low. A beat passes the
// line store read, window update, column sums, row sums and the reciprocal
// multiply into a 32-entry result FIFO. o_stall is raised from FIFO credit
// only: when the FIFO cannot hold three results for every beat in flight and
// the one offered. Reset is synchronous; line store contents are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module box_filter_5x5_mirror_core
    import bfm_pkg::*;
#(
    parameter int MAX_SIZE = 256
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [1:0] i_cfg_index,
    input  wire logic [8:0] i_cfg_data,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic       i_action,
    input  wire logic [7:0] i_in_ch0,
    input  wire logic [7:0] i_in_ch1,
    input  wire logic [7:0] i_in_ch2,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic [7:0]      o_out_ch0,
    output logic [7:0]      o_out_ch1,
    output logic [7:0]      o_out_ch2,
    output logic            o_row_end,
    output logic            o_frame_end
);

    localparam int AW = $clog2(MAX_SIZE);

    // configuration
    logic [8:0] r_size;
    logic [1:0] r_chans;
    logic [8:0] s_eff;
    logic [1:0] nch;
    logic signed [11:0] s_sg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size  <= 9'd256;
            r_chans <= 2'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_IMAGE_SIZE:    r_size  <= i_cfg_data;
                REG_CHANNEL_COUNT: r_chans <= i_cfg_data[1:0];
                default:           ;
            endcase
        end
    end

    always_comb begin
        s_eff = r_size;
        if (32'(r_size) > MAX_SIZE) begin
            s_eff = 9'(MAX_SIZE);
        end
        if (s_eff < 9'd3) begin
            s_eff = 9'd3;
        end
    end

    assign nch  = (r_chans == 2'd0) ? 2'd1 : r_chans;
    assign s_sg = signed'({3'b000, s_eff});

    // ---------------- stage 0: position counters and line store read
    logic [CW-1:0] r_row, r_col, n_row, n_col;
    logic [CW-1:0] cur_r, cur_c, inc_c, inc_r;
    logic          wrap, is_real, acc, launch;
    t_pix          pix;

    logic          r_s1_valid, r_s2_valid, r_s3_valid, r_s4_valid;
    t_pix          r_s1_pix;
    logic [CW-1:0] r_s1_r, r_s1_c;

    logic [FIFO_CNTW-1:0] fifo_count;
    logic [2:0]           inflight;

    assign inflight = 3'(r_s1_valid) + 3'(r_s2_valid) + 3'(r_s3_valid) + 3'(r_s4_valid);
    assign o_stall  = (7'(fifo_count) + (7'(inflight) + 7'd1) * 7'd3) > 7'(FIFO_DEPTH);

    always_comb begin
        wrap    = (r_row >= {1'b0, s_eff} + CW'(RAD)) || (r_col >= {1'b0, s_eff});
        cur_r   = wrap ? '0 : r_row;
        cur_c   = wrap ? '0 : r_col;
        is_real = cur_r < {1'b0, s_eff};
        acc     = i_valid && !o_stall;
        launch  = acc && !(is_real && i_action);
        pix     = '0;
        if (is_real) begin
            pix[7:0] = i_in_ch0;
            if (nch >= 2'd2) begin
                pix[15:8] = i_in_ch1;
            end
            if (nch == 2'd3) begin
                pix[23:16] = i_in_ch2;
            end
        end
        inc_c = cur_c + CW'(1);
        inc_r = cur_r;
        if (inc_c >= {1'b0, s_eff}) begin
            inc_c = '0;
            inc_r = cur_r + CW'(1);
            if (inc_r >= {1'b0, s_eff} + CW'(RAD)) begin
                inc_r = '0;
            end
        end
        n_row = r_row;
        n_col = r_col;
        if (i_cfg_we &&
            (i_cfg_index == REG_IMAGE_SIZE || i_cfg_index == REG_CHANNEL_COUNT)) begin
            n_row = '0;
            n_col = '0;
        end else if (launch) begin
            n_row = inc_r;
            n_col = inc_c;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row      <= '0;
            r_col      <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_row      <= n_row;
            r_col      <= n_col;
            r_s1_valid <= launch;
        end
    end

    always_ff @(posedge i_clk) begin
        if (launch) begin
            r_s1_pix <= pix;
            r_s1_r   <= cur_r;
            r_s1_c   <= cur_c;
        end
    end

    // ---------------- stage 1: line shift, window shift, tap indexes
    t_pix rd [LANES];
    t_pix wd [LANES];

    for (genvar k = 0; k < LANES; k++) begin : g_lane
        if (k == 0) begin : g_first
            assign wd[k] = r_s1_pix;
        end else begin : g_next
            assign wd[k] = rd[k-1];
        end
        bfm_ram #(
            .WIDTH ($bits(t_pix)),
            .DEPTH (MAX_SIZE)
        ) u_line (
            .i_clk   (i_clk),
            .i_we    (r_s1_valid),
            .i_waddr (r_s1_c[AW-1:0]),
            .i_wdata (wd[k]),
            .i_raddr (cur_c[AW-1:0]),
            .o_rdata (rd[k])
        );
    end

    t_pix r_win [WIN][WIN];
    t_pix vec   [WIN];

    always_comb begin
        vec[WIN-1] = r_s1_pix;
        for (int k = 0; k < LANES; k++) begin
            vec[WIN-2-k] = rd[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int y = 0; y < WIN; y++) begin
                for (int x = 0; x < WIN; x++) begin
                    r_win[y][x] <= '0;
                end
            end
        end else if (r_s1_valid) begin
            for (int y = 0; y < WIN; y++) begin
                for (int x = 0; x < WIN - 1; x++) begin
                    r_win[y][x] <= r_win[y][x+1];
                end
                r_win[y][WIN-1] <= vec[y];
            end
        end
    end

    logic               emit, last_col;
    logic [1:0]         s1_cnt;
    logic signed [11:0] rnow, cnow, orow, ocol;
    logic [2:0]         ty [WIN];
    logic [2:0]         tx [3][WIN];
    logic [2:0]         re, fe;

    always_comb begin
        rnow     = signed'({2'b00, r_s1_r});
        cnow     = signed'({2'b00, r_s1_c});
        orow     = rnow - 12'(RAD);
        emit     = (r_s1_r >= CW'(RAD)) && (r_s1_c >= CW'(RAD));
        last_col = (r_s1_c == {1'b0, s_eff} - CW'(1));
        s1_cnt   = last_col ? 2'd3 : 2'd1;
        ocol     = '0;
        for (int d = 0; d < WIN; d++) begin
            ty[d] = f_tap(orow + 12'(d) - 12'(RAD), s_sg, rnow);
        end
        for (int j = 0; j < 3; j++) begin
            ocol = cnow - 12'(RAD) + 12'(j);
            for (int d = 0; d < WIN; d++) begin
                tx[j][d] = f_tap(ocol + 12'(d) - 12'(RAD), s_sg, cnow);
            end
            re[j] = (ocol == s_sg - 12'sd1);
            fe[j] = re[j] && (orow == s_sg - 12'sd1);
        end
    end

    logic [2:0] r_s2_ty [WIN];
    logic [2:0] r_s2_tx [3][WIN];
    logic [2:0] r_s2_re, r_s2_fe;
    logic [1:0] r_s2_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= r_s1_valid && emit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_ty  <= ty;
        r_s2_tx  <= tx;
        r_s2_re  <= re;
        r_s2_fe  <= fe;
        r_s2_cnt <= s1_cnt;
    end

    // ---------------- stage 2: vertical sums per window column
    logic [10:0] colsum [WIN][3];
    t_pix        tap_px;

    always_comb begin
        tap_px = '0;
        for (int x = 0; x < WIN; x++) begin
            for (int ch = 0; ch < 3; ch++) begin
                colsum[x][ch] = '0;
            end
            for (int d = 0; d < WIN; d++) begin
                case (r_s2_ty[d])
                    3'd0:    tap_px = r_win[0][x];
                    3'd1:    tap_px = r_win[1][x];
                    3'd2:    tap_px = r_win[2][x];
                    3'd3:    tap_px = r_win[3][x];
                    default: tap_px = r_win[4][x];
                endcase
                for (int ch = 0; ch < 3; ch++) begin
                    colsum[x][ch] = colsum[x][ch] + 11'(tap_px[8*ch +: 8]);
                end
            end
        end
    end

    logic [10:0] r_s3_colsum [WIN][3];
    logic [2:0]  r_s3_tx [3][WIN];
    logic [2:0]  r_s3_re, r_s3_fe;
    logic [1:0]  r_s3_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else begin
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s3_colsum <= colsum;
        r_s3_tx     <= r_s2_tx;
        r_s3_re     <= r_s2_re;
        r_s3_fe     <= r_s2_fe;
        r_s3_cnt    <= r_s2_cnt;
    end

    // ---------------- stage 3: horizontal sums per output slot
    logic [12:0] boxsum [3][3];
    logic [10:0] col_px [3];

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            col_px[ch] = '0;
        end
        for (int j = 0; j < 3; j++) begin
            for (int ch = 0; ch < 3; ch++) begin
                boxsum[j][ch] = '0;
            end
            for (int d = 0; d < WIN; d++) begin
                for (int ch = 0; ch < 3; ch++) begin
                    case (r_s3_tx[j][d])
                        3'd0:    col_px[ch] = r_s3_colsum[0][ch];
                        3'd1:    col_px[ch] = r_s3_colsum[1][ch];
                        3'd2:    col_px[ch] = r_s3_colsum[2][ch];
                        3'd3:    col_px[ch] = r_s3_colsum[3][ch];
                        default: col_px[ch] = r_s3_colsum[4][ch];
                    endcase
                    boxsum[j][ch] = boxsum[j][ch] + 13'(col_px[ch]);
                end
            end
        end
    end

    logic [12:0] r_s4_sum [3][3];
    logic [2:0]  r_s4_re, r_s4_fe;
    logic [1:0]  r_s4_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_valid <= 1'b0;
        end else begin
            r_s4_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s4_sum <= boxsum;
        r_s4_re  <= r_s3_re;
        r_s4_fe  <= r_s3_fe;
        r_s4_cnt <= r_s3_cnt;
    end

    // ---------------- stage 4: divide by 25 through the reciprocal
    t_res_group  grp;
    logic [25:0] prod [3][3];
    logic [7:0]  quo  [3][3];

    always_comb begin
        grp     = '0;
        grp.cnt = r_s4_valid ? r_s4_cnt : 2'd0;
        for (int j = 0; j < 3; j++) begin
            for (int ch = 0; ch < 3; ch++) begin
                prod[j][ch] = 26'(r_s4_sum[j][ch]) * 26'(RECIP);
                quo[j][ch]  = (2'(ch) < nch) ? prod[j][ch][RECIP_SHIFT +: 8] : 8'd0;
            end
            grp.slot[j].ch0       = quo[j][0];
            grp.slot[j].ch1       = quo[j][1];
            grp.slot[j].ch2       = quo[j][2];
            grp.slot[j].row_end   = r_s4_re[j];
            grp.slot[j].frame_end = r_s4_fe[j];
        end
    end

    t_res res;

    bfm_res_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (grp),
        .o_count (fifo_count),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_res   (res)
    );

    assign o_out_ch0   = res.ch0;
    assign o_out_ch1   = res.ch1;
    assign o_out_ch2   = res.ch2;
    assign o_row_end   = res.row_end;
    assign o_frame_end = res.frame_end;

endmodule

`default_nettype wire

[design/bfm_ram.sv]
// ----------------------------------------------------------------------------
// bfm_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module bfm_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[design/bfm_res_fifo.sv]
// ----------------------------------------------------------------------------
// bfm_res_fifo: result FIFO with up to three writes per cycle
// Takes a group of one to three results per cycle and hands them out one
// beat at a time on a valid/stall channel.
// ----------------------------------------------------------------------------
`default_nettype none

module bfm_res_fifo
    import bfm_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_res_group           i_wr,
    output logic      [FIFO_CNTW-1:0] o_count,
    output logic                      o_valid,
    input  wire logic                 i_stall,
    output t_res                      o_res
);

    t_res                 r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   r_wptr;
    logic [FIFO_AW-1:0]   r_rptr;
    logic [FIFO_CNTW-1:0] r_count;
    logic [FIFO_CNTW-1:0] n_count;
    logic                 pop;

    assign o_valid = (r_count != '0);
    assign pop     = o_valid && !i_stall;
    assign n_count = r_count + FIFO_CNTW'(i_wr.cnt) - FIFO_CNTW'(pop);

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < 3; j++) begin
            if (2'(j) < i_wr.cnt) begin
                r_mem[FIFO_AW'(r_wptr + FIFO_AW'(j))] <= i_wr.slot[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= r_wptr + FIFO_AW'(i_wr.cnt);
            r_rptr  <= r_rptr + FIFO_AW'(pop);
            r_count <= n_count;
        end
    end

    assign o_count = r_count;
    assign o_res   = r_mem[r_rptr];

endmodule

`default_nettype wire

[tb/sv/box_filter_5x5_mirror_core_tb.sv]
// ----------------------------------------------------------------------------
// box_filter_5x5_mirror_core_tb: self-checking bench of the mirrored box filter
// Streams raster frames of several sizes and channel counts, with noise
// beats and cut-off frames. A local model of the line store and the window
// predicts every result, and a monitor compares each output beat in order.
// ----------------------------------------------------------------------------
`default_nettype none

module box_filter_5x5_mirror_core_tb;
    import bfm_pkg::*;

    localparam int MAXS       = 256;
    localparam int SETTLE     = 24;
    localparam int CYCLE_STOP = 600000;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_we = 1'b0;
    logic [1:0] i_cfg_index = '0;
    logic [8:0] i_cfg_data = '0;
    logic       i_valid = 1'b0;
    logic       o_stall;
    logic       i_action = 1'b0;
    logic [7:0] i_in_ch0 = '0;
    logic [7:0] i_in_ch1 = '0;
    logic [7:0] i_in_ch2 = '0;
    logic       o_valid;
    logic       i_stall = 1'b0;
    logic [7:0] o_out_ch0;
    logic [7:0] o_out_ch1;
    logic [7:0] o_out_ch2;
    logic       o_row_end;
    logic       o_frame_end;

    box_filter_5x5_mirror_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_action    (i_action),
        .i_in_ch0    (i_in_ch0),
        .i_in_ch1    (i_in_ch1),
        .i_in_ch2    (i_in_ch2),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_out_ch0   (o_out_ch0),
        .o_out_ch1   (o_out_ch1),
        .o_out_ch2   (o_out_ch2),
        .o_row_end   (o_row_end),
        .o_frame_end (o_frame_end)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // filter model state
    logic [23:0] line_mem [LANES][MAXS];
    logic [23:0] win_q [WIN][WIN];
    int          row_q;
    int          col_q;
    logic [8:0]  size_q;
    logic [1:0]  chans_q;
    t_res        mean_q [$];

    int err_cnt;
    int cycle_cnt;
    int src_idle_pct;
    int rcv_idle_pct;

    function automatic int eff_size();
        if (size_q > 9'(MAXS)) return MAXS;
        if (size_q < 9'd3) return 3;
        return int'(size_q);
    endfunction

    function automatic int eff_chans();
        return (chans_q == 2'd0) ? 1 : int'(chans_q);
    endfunction

    function automatic int win_slot(input int v, input int s, input int now);
        int m;
        int t;
        m = (v < 0) ? -v : v;
        if (m >= s) m = 2 * (s - 1) - m;
        if (m < 0) m = 0;
        if (m > s - 1) m = s - 1;
        t = m - (now - 2 * RAD);
        if (t < 0) return 0;
        if (t > 2 * RAD) return 2 * RAD;
        return t;
    endfunction

    function automatic t_res box_mean(input int orow, input int ocol, input int rnow,
                                      input int cnow, input int s, input int nch);
        t_res        res;
        int          sum;
        logic [7:0]  mean [3];
        for (int ch = 0; ch < 3; ch++) begin
            sum = 0;
            for (int dy = -RAD; dy <= RAD; dy++) begin
                for (int dx = -RAD; dx <= RAD; dx++) begin
                    sum += win_q[win_slot(orow + dy, s, rnow)]
                                [win_slot(ocol + dx, s, cnow)][8*ch +: 8];
                end
            end
            mean[ch] = (ch < nch) ? 8'(sum / (WIN * WIN)) : 8'd0;
        end
        res.ch0       = mean[0];
        res.ch1       = mean[1];
        res.ch2       = mean[2];
        res.row_end   = (ocol == s - 1);
        res.frame_end = (ocol == s - 1) && (orow == s - 1);
        return res;
    endfunction

    task automatic predict_beat(input logic act, input logic [7:0] a, input logic [7:0] b,
                                input logic [7:0] c2);
        int          s;
        int          nch;
        int          r;
        int          c;
        int          last;
        logic [23:0] mask;
        logic [23:0] pix;
        logic [23:0] vec [WIN];
        s = eff_size();
        nch = eff_chans();
        r = row_q;
        c = col_q;
        if (r >= s + RAD || c >= s) begin
            r = 0;
            c = 0;
        end
        // drain beat inside the image: drop it
        if (r < s && act) return;
        mask = (nch >= 3) ? 24'hFFFFFF : ((nch == 2) ? 24'h00FFFF : 24'h0000FF);
        pix = (r < s) ? ({c2, b, a} & mask) : 24'h0;
        vec[2*RAD] = pix;
        for (int l = 0; l < LANES; l++) vec[2*RAD-1-l] = line_mem[l][c];
        for (int l = LANES - 1; l > 0; l--) line_mem[l][c] = line_mem[l-1][c];
        line_mem[0][c] = pix;
        for (int y = 0; y < WIN; y++) begin
            for (int x = 0; x < WIN - 1; x++) win_q[y][x] = win_q[y][x+1];
            win_q[y][WIN-1] = vec[y];
        end
        if (r >= RAD && c >= RAD) begin
            last = (c == s - 1) ? s - 1 : c - RAD;
            for (int col = c - RAD; col <= last; col++) begin
                mean_q.push_back(box_mean(r - RAD, col, r, c, s, nch));
            end
        end
        c++;
        if (c >= s) begin
            c = 0;
            r++;
            if (r >= s + RAD) r = 0;
        end
        row_q = r;
        col_q = c;
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        err_cnt++;
    endtask

    // result monitor
    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (mean_q.size() == 0) begin
                report_mismatch("unexpected beat", 1, 0);
            end else begin
                want = mean_q.pop_front();
                if (o_out_ch0 != want.ch0) report_mismatch("out_ch0", o_out_ch0, want.ch0);
                if (o_out_ch1 != want.ch1) report_mismatch("out_ch1", o_out_ch1, want.ch1);
                if (o_out_ch2 != want.ch2) report_mismatch("out_ch2", o_out_ch2, want.ch2);
                if (o_row_end != want.row_end)
                    report_mismatch("row_end", o_row_end, want.row_end);
                if (o_frame_end != want.frame_end)
                    report_mismatch("frame_end", o_frame_end, want.frame_end);
            end
        end
    end

    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(0, 99) < rcv_idle_pct);
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_STOP) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance,
    // with valid left high so back-to-back beats need no second assignment.
    task automatic send_beat(input logic act, input logic [7:0] a, input logic [7:0] b,
                             input logic [7:0] c2);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid  <= 1'b1;
        i_action <= act;
        i_in_ch0 <= a;
        i_in_ch1 <= b;
        i_in_ch2 <= c2;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predict_beat(act, a, b, c2);
        @(negedge i_clk);
    endtask

    // drop valid, wait out the results and the pipeline
    task automatic settle();
        i_valid <= 1'b0;
        while (mean_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [8:0] data);
        settle();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_IMAGE_SIZE) size_q = data;
        else if (idx == REG_CHANNEL_COUNT) chans_q = data[1:0];
        if (idx == REG_IMAGE_SIZE || idx == REG_CHANNEL_COUNT) begin
            row_q = 0;
            col_q = 0;
        end
    endtask

    function automatic logic [7:0] pick_sample(input bit extreme);
        if (extreme) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
        return 8'($urandom);
    endfunction

    // Stream one frame until the counters wrap, or stop after max_beats.
    // Mostly well formed; noise puts drain beats in the image and pixels
    // in the drain rows.
    task automatic stream_frame(input int max_beats, input bit extreme, inout int beats);
        int  n;
        bit  moved;
        bit  act;
        n = 0;
        moved = 0;
        do begin
            if (row_q < eff_size()) act = ($urandom_range(0, 9) == 0);
            else act = ($urandom_range(0, 9) != 0);
            send_beat(act, pick_sample(extreme), pick_sample(extreme), pick_sample(extreme));
            n++;
            if (row_q != 0 || col_q != 0) moved = 1;
        end while (!(moved && row_q == 0 && col_q == 0) && n < max_beats);
        beats += n;
    endtask

    task automatic test_reset_size();
        int beats;
        beats = 0;
        // default 256 x 256, one channel: a short burst gives no output yet
        stream_frame(24, 1'b0, beats);
    endtask

    task automatic test_min_frame();
        int beats;
        beats = 0;
        write_reg(REG_IMAGE_SIZE, 9'd0);
        write_reg(REG_CHANNEL_COUNT, 9'd3);
        write_reg(2'd2, 9'h1FF);
        write_reg(2'd3, 9'h0AA);
        send_beat(1'b1, 8'hFF, 8'hFF, 8'hFF);
        stream_frame(40, 1'b1, beats);
        write_reg(REG_IMAGE_SIZE, 9'd3);
        write_reg(REG_CHANNEL_COUNT, 9'h1FE);
        stream_frame(40, 1'b1, beats);
    endtask

    task automatic test_wide_clamp();
        int beats;
        beats = 0;
        write_reg(REG_IMAGE_SIZE, 9'h1FF);
        write_reg(REG_CHANNEL_COUNT, 9'h0FC);
        stream_frame(24, 1'b0, beats);
        write_reg(REG_IMAGE_SIZE, 9'd256);
        write_reg(REG_CHANNEL_COUNT, 9'd3);
        stream_frame(24, 1'b0, beats);
    endtask

    task automatic test_random_frames(input int src_pct, input int rcv_pct, input int goal);
        int beats;
        int cut;
        beats = 0;
        src_idle_pct = src_pct;
        rcv_idle_pct = rcv_pct;
        while (beats < goal) begin
            write_reg(REG_IMAGE_SIZE, 9'($urandom_range(3, 8)));
            write_reg(REG_CHANNEL_COUNT, {7'($urandom), 2'($urandom_range(0, 3))});
            // now and then cut a frame short and restart by config
            cut = ($urandom_range(0, 6) == 0) ? $urandom_range(1, 30) : 1000;
            stream_frame(cut, ($urandom_range(0, 4) == 0), beats);
        end
    endtask

    initial begin
        err_cnt = 0;
        cycle_cnt = 0;
        src_idle_pct = 12;
        rcv_idle_pct = 59;
        row_q = 0;
        col_q = 0;
        size_q = 9'd256;
        chans_q = 2'd1;
        for (int l = 0; l < LANES; l++)
            for (int x = 0; x < MAXS; x++) line_mem[l][x] = '0;
        for (int y = 0; y < WIN; y++)
            for (int x = 0; x < WIN; x++) win_q[y][x] = '0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_size();
        test_min_frame();
        test_wide_clamp();
        test_random_frames(12, 59, 40);
        test_random_frames(59, 12, 40);
        test_random_frames(0, 0, 40);

        settle();
        if (err_cnt == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire

[sim.f]
design/bfm_pkg.sv
design/bfm_ram.sv
design/bfm_res_fifo.sv
design/box_filter_5x5_mirror_core.sv
tb/sv/box_filter_5x5_mirror_core_tb.sv
